/* rtl/board_control_status_register_assert.svh */
// Assertion macros shared by the board control and status register RTL.
`ifndef BOARD_CONTROL_STATUS_REGISTER_ASSERT_SVH
`define BOARD_CONTROL_STATUS_REGISTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bcsr_pkg.sv */
// Types, constants and lookup functions for the board control and status register.
`timescale 1ns / 1ps

package bcsr_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OFFSET_W  = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IRQ_W     = 11;
    localparam int unsigned IRQ_IDX_W = 4;
    localparam int unsigned BIT_IDX_W = 5;

    localparam logic [DATA_W-1:0] CSR_RESET_VALUE = 32'h0010_6180;

    // Inhibit bits for the conditional error interrupts.
    localparam logic [BIT_IDX_W-1:0] BIT_INHIBIT_TMO   = 5'd9;
    localparam logic [BIT_IDX_W-1:0] BIT_INHIBIT_SBERR = 5'd11;

    // Interrupt line numbers.
    localparam logic [IRQ_IDX_W-1:0] IRQ_CLOCK = 4'd0;
    localparam logic [IRQ_IDX_W-1:0] IRQ_PWRDN = 4'd1;
    localparam logic [IRQ_IDX_W-1:0] IRQ_BUSOP = 4'd2;
    localparam logic [IRQ_IDX_W-1:0] IRQ_UART  = 4'd3;
    localparam logic [IRQ_IDX_W-1:0] IRQ_DMA   = 4'd4;
    localparam logic [IRQ_IDX_W-1:0] IRQ_PIR9  = 4'd5;
    localparam logic [IRQ_IDX_W-1:0] IRQ_PIR8  = 4'd6;
    localparam logic [IRQ_IDX_W-1:0] IRQ_SBERR = 4'd7;
    localparam logic [IRQ_IDX_W-1:0] IRQ_MBERR = 4'd8;
    localparam logic [IRQ_IDX_W-1:0] IRQ_RXF   = 4'd9;
    localparam logic [IRQ_IDX_W-1:0] IRQ_TMO   = 4'd10;

    // Byte offsets with special side effects.
    localparam logic [OFFSET_W-1:0] OFF_TIMER_INTERVAL = 8'h1c;
    localparam logic [OFFSET_W-1:0] OFF_TIMER_SANITY   = 8'h20;
    localparam logic [OFFSET_W-1:0] OFF_TIMER_BUS      = 8'h24;
    localparam logic [OFFSET_W-1:0] OFF_NMI_A          = 8'h3c;
    localparam logic [OFFSET_W-1:0] OFF_POWER_SWITCH   = 8'h44;
    localparam logic [OFFSET_W-1:0] OFF_FLOPPY_SIDE    = 8'h4c;
    localparam logic [OFFSET_W-1:0] OFF_SBERR          = 8'h5c;
    localparam logic [OFFSET_W-1:0] OFF_TIMEOUT        = 8'h68;
    localparam logic [OFFSET_W-1:0] OFF_NMI_B          = 8'h74;
    localparam logic [OFFSET_W-1:0] OFF_NMI_C          = 8'h78;
    localparam logic [OFFSET_W-1:0] OFF_SYS_RESET      = 8'h7c;

    // Read byte selects on offset bits 7:4.
    localparam logic [3:0] RD_SEL_BYTE0 = 4'h0;
    localparam logic [3:0] RD_SEL_BYTE1 = 4'h2;
    localparam logic [3:0] RD_SEL_BYTE2 = 4'h4;
    localparam logic [3:0] RD_SEL_BYTE3 = 4'h6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] NMI_NONE     = 2'd0;
    localparam logic [1:0] NMI_ASSERT   = 2'd1;
    localparam logic [1:0] NMI_DEASSERT = 2'd2;

    localparam logic [1:0] TMR_INTERVAL = 2'd0;
    localparam logic [1:0] TMR_SANITY   = 2'd1;
    localparam logic [1:0] TMR_BUS      = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   write_data;
    } bcsr_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_set_mask;
        logic [IRQ_W-1:0]  irq_clear_mask;
        logic [1:0]        nmi_action;
        logic              timer_gate_valid;
        logic [1:0]        timer_select;
        logic              timer_gate_level;
        logic              power_down_request;
        logic              reset_request;
        logic              floppy_side_valid;
        logic              floppy_side;
        logic [DATA_W-1:0] register_value;
    } bcsr_rsp_t;

    typedef struct packed {
        logic                 hit;
        logic [IRQ_IDX_W-1:0] line;
    } bcsr_irq_map_t;

    // Plain interrupt line tied to each register bit, if any.
    function automatic bcsr_irq_map_t irq_of_bit(input logic [BIT_IDX_W-1:0] n);
        bcsr_irq_map_t m;
        m = '0;
        unique case (n)
            5'd0:  m = '{hit: 1'b1, line: IRQ_CLOCK};
            5'd1:  m = '{hit: 1'b1, line: IRQ_PWRDN};
            5'd2:  m = '{hit: 1'b1, line: IRQ_BUSOP};
            5'd3:  m = '{hit: 1'b1, line: IRQ_UART};
            5'd4:  m = '{hit: 1'b1, line: IRQ_DMA};
            5'd5:  m = '{hit: 1'b1, line: IRQ_PIR9};
            5'd6:  m = '{hit: 1'b1, line: IRQ_PIR8};
            5'd24: m = '{hit: 1'b1, line: IRQ_MBERR};
            5'd25: m = '{hit: 1'b1, line: IRQ_RXF};
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/board_control_status_register.sv */
// Top level of the board control and status register: request and response pipeline.
`timescale 1ns / 1ps
//
// Bus-facing control and status register with one request channel and one
// response channel, both valid/ready. Each request (read or write, byte
// offset, write data) produces exactly one response carrying the read byte,
// the interrupt set and clear masks, NMI, timer gate, power-down, reset and
// floppy side actions, and the full register value after the access.
// A request is captured in an input register, decoded combinationally
// against the current register contents, and the response lands in an
// output register. Throughput is one request per cycle while the receiver
// holds ready high; the input register refills in the same cycle that its
// request moves to the output register.
// The register value updates when a request moves into the output register,
// so every request sees the effect of all earlier ones.
// Reset (rst_n low) loads the register with 0x00106180 and empties both
// pipeline registers. When the receiver holds ready low, the response and
// one more request are held, and ready on the request side then drops.
//
`include "board_control_status_register_assert.svh"

module board_control_status_register (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bcsr_pkg::bcsr_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output bcsr_pkg::bcsr_rsp_t  rsp
);
    import bcsr_pkg::*;

    bcsr_req_t          req_reg;
    logic               req_valid_reg;
    bcsr_rsp_t          rsp_reg;
    bcsr_rsp_t          rsp_next;
    logic               rsp_valid_reg;
    logic [DATA_W-1:0]  status_reg;
    logic [DATA_W-1:0]  status_next;
    logic               advance;

    bcsr_decode u_decode (
        .req         (req_reg),
        .status      (status_reg),
        .rsp         (rsp_next),
        .status_next (status_next)
    );

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= CSR_RESET_VALUE;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `BCSR_ASSERT_SAME(a_value_tracks_status, rsp_valid_reg,
        rsp_reg.register_value == status_reg, "response value differs from register")
    `BCSR_ASSERT_SAME(a_reset_restores, rsp_valid_reg && rsp_reg.reset_request,
        rsp_reg.register_value == CSR_RESET_VALUE, "system reset did not restore value")
    `BCSR_ASSERT_SAME(a_masks_disjoint, rsp_valid_reg,
        (rsp_reg.irq_set_mask & rsp_reg.irq_clear_mask) == '0, "line both set and cleared")
    `BCSR_ASSERT_SAME(a_read_no_action, rsp_valid_reg && (rsp_reg.read_data != '0),
        (rsp_reg.irq_set_mask == '0) && (rsp_reg.nmi_action == NMI_NONE),
        "read request carried an action")
    `BCSR_ASSERT_NEXT(a_status_only_on_advance, !advance,
        $stable(status_reg), "register changed without a request")

endmodule

/* rtl/bcsr_decode.sv */
// Access decode: computes the response and the next register value for one request.
`timescale 1ns / 1ps

module bcsr_decode (
    input  bcsr_pkg::bcsr_req_t                req,
    input  logic [bcsr_pkg::DATA_W-1:0]        status,
    output bcsr_pkg::bcsr_rsp_t                rsp,
    output logic [bcsr_pkg::DATA_W-1:0]        status_next
);
    import bcsr_pkg::*;

    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 write_ok;
    logic                 on;
    bcsr_irq_map_t        irq_map;

    // Aligned writes up to 0x7c are the only ones with an effect.
    assign bit_idx  = req.offset[BIT_IDX_W+1:2];
    assign write_ok = (req.operation == OP_WRITE) && (req.offset[1:0] == 2'b00)
                      && !req.offset[OFFSET_W-1];
    assign on       = (req.offset == OFF_FLOPPY_SIDE) ? req.write_data[0]
                                                      : (|req.write_data);
    assign irq_map  = irq_of_bit(bit_idx);

    always_comb
    begin
        rsp         = '0;
        status_next = status;
        if (req.operation == OP_READ)
        begin
            unique case (req.offset[7:4])
                RD_SEL_BYTE0: rsp.read_data = status[7:0];
                RD_SEL_BYTE1: rsp.read_data = status[15:8];
                RD_SEL_BYTE2: rsp.read_data = status[23:16];
                RD_SEL_BYTE3: rsp.read_data = status[31:24];
                default:      rsp.read_data = '0;
            endcase
        end
        else if (write_ok)
        begin
            if (req.offset == OFF_SYS_RESET)
            begin
                status_next       = CSR_RESET_VALUE;
                rsp.reset_request = 1'b1;
            end
            else
            begin
                status_next[bit_idx] = on;
                if (irq_map.hit)
                begin
                    rsp.irq_set_mask[irq_map.line]   = on;
                    rsp.irq_clear_mask[irq_map.line] = !on;
                end
                unique case (req.offset)
                    OFF_TIMER_INTERVAL:
                    begin
                        rsp.timer_gate_valid = 1'b1;
                        rsp.timer_select     = TMR_INTERVAL;
                        rsp.timer_gate_level = on;
                    end
                    OFF_TIMER_SANITY:
                    begin
                        rsp.timer_gate_valid = 1'b1;
                        rsp.timer_select     = TMR_SANITY;
                        rsp.timer_gate_level = on;
                    end
                    OFF_TIMER_BUS:
                    begin
                        rsp.timer_gate_valid = 1'b1;
                        rsp.timer_select     = TMR_BUS;
                        rsp.timer_gate_level = on;
                    end
                    OFF_NMI_A, OFF_NMI_B, OFF_NMI_C:
                        rsp.nmi_action = on ? NMI_ASSERT : NMI_DEASSERT;
                    OFF_POWER_SWITCH:
                        rsp.power_down_request = !on;
                    OFF_FLOPPY_SIDE:
                    begin
                        rsp.floppy_side_valid = 1'b1;
                        rsp.floppy_side       = !on;
                    end
                    // The inhibit bits sit at other positions, so the old value is current.
                    OFF_SBERR:
                    begin
                        rsp.irq_clear_mask[IRQ_SBERR] = !on;
                        rsp.irq_set_mask[IRQ_SBERR]   = on && !status[BIT_INHIBIT_SBERR];
                    end
                    OFF_TIMEOUT:
                    begin
                        rsp.irq_clear_mask[IRQ_TMO] = !on;
                        rsp.irq_set_mask[IRQ_TMO]   = on && !status[BIT_INHIBIT_TMO];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        rsp.register_value = status_next;
    end

endmodule
